>>> design/assert_macros.svh
// Assertion helpers. The enclosing module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define GTP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define GTP_ASSERT_NEVER(label, expr, msg) \
    `GTP_ASSERT(label, !(expr), msg)

`endif

>>> design/gtp_pkg.sv
`default_nettype none

package gtp_pkg;

    localparam int FRAME_WIDTH_DEFAULT  = 240;
    localparam int FRAME_HEIGHT_DEFAULT = 320;

    localparam int FRAME_CNT_W = 8;
    localparam int ROW_W       = 9;
    localparam int COL_W       = 8;
    localparam int CFG_W       = 8;
    localparam int IDX_W       = 8;
    localparam int PIXEL_W     = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_X_SPAN     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_SPAN     = 2'd2;

    localparam logic [CFG_W-1:0] PHASE_STEP_RESET = 8'd3;
    localparam logic [CFG_W-1:0] X_SPAN_RESET     = 8'd156;
    localparam logic [CFG_W-1:0] Y_SPAN_RESET     = 8'd100;

    typedef struct packed {
        logic [CFG_W-1:0] phase_step;
        logic [CFG_W-1:0] x_span;
        logic [CFG_W-1:0] y_span;
    } cfg_t;

    localparam int STOP_COUNT = 5;
    localparam int SEG_COUNT  = STOP_COUNT - 1;
    localparam int SEG_W      = 2;
    localparam int CHAN_COUNT = 3;

    typedef logic [SEG_W-1:0] seg_t;

    localparam int STOP_POS [STOP_COUNT] = '{0, 58, 118, 185, 255};

    // Color stops in red, green, blue order.
    localparam int STOP_RGB [STOP_COUNT][CHAN_COUNT] = '{
        '{20, 34, 105},
        '{0, 205, 255},
        '{70, 255, 150},
        '{255, 190, 65},
        '{245, 65, 190}
    };

    localparam int SEG_SPAN [SEG_COUNT] = '{
        STOP_POS[1] - STOP_POS[0],
        STOP_POS[2] - STOP_POS[1],
        STOP_POS[3] - STOP_POS[2],
        STOP_POS[4] - STOP_POS[3]
    };

    // The blend position is (offset*255)/span, done as a multiply by a rounded-up
    // reciprocal. The numerator stays below 2^15 and the span below 2^7, so a
    // shift of 22 makes the quotient exact.
    localparam int T_NUM_W   = 15;
    localparam int T_SHIFT   = 22;
    localparam int T_RECIP_W = 17;
    localparam int T_PROD_W  = T_NUM_W + T_RECIP_W;

    localparam int T_RECIP [SEG_COUNT] = '{
        ((1 << T_SHIFT) + SEG_SPAN[0] - 1) / SEG_SPAN[0],
        ((1 << T_SHIFT) + SEG_SPAN[1] - 1) / SEG_SPAN[1],
        ((1 << T_SHIFT) + SEG_SPAN[2] - 1) / SEG_SPAN[2],
        ((1 << T_SHIFT) + SEG_SPAN[3] - 1) / SEG_SPAN[3]
    };

    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   palette_index;
        seg_t               seg;
        logic [T_NUM_W-1:0] num;
    } idx_beat_t;

    // The first segment whose upper stop is not below the index.
    function automatic seg_t seg_of(input logic [IDX_W-1:0] idx);
        seg_t s;
        s = seg_t'(SEG_COUNT - 1);
        for (int k = SEG_COUNT - 1; k >= 0; k--)
        begin
            if (idx <= IDX_W'(STOP_POS[k + 1]))
            begin
                s = seg_t'(k);
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> design/gtp_req_if.sv
`default_nettype none

interface gtp_req_if;
    logic                            valid;
    logic                            ready;
    logic [gtp_pkg::FRAME_CNT_W-1:0] frame_count;
    logic [gtp_pkg::ROW_W-1:0]       row;
    logic [gtp_pkg::COL_W-1:0]       column;

    modport source (output valid, output frame_count, output row, output column,
                    input ready);
    modport sink   (input valid, input frame_count, input row, input column,
                    output ready);
endinterface

`default_nettype wire

>>> design/gtp_pix_if.sv
`default_nettype none

interface gtp_pix_if;
    logic                        valid;
    logic                        ready;
    logic [gtp_pkg::PIXEL_W-1:0] pixel_word;
    logic [gtp_pkg::IDX_W-1:0]   palette_index;

    modport source (output valid, output pixel_word, output palette_index, input ready);
    modport sink   (input valid, input pixel_word, input palette_index, output ready);
endinterface

`default_nettype wire

>>> design/gtp_cfg_if.sv
`default_nettype none

interface gtp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gtp_pkg::CFG_INDEX_W-1:0] index;
    logic [gtp_pkg::CFG_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/gtp_cfg_regs.sv
`default_nettype none
`include "assert_macros.svh"

module gtp_cfg_regs (
    input  wire logic     clk,
    input  wire logic     rst_n,
    gtp_cfg_if.sink       cfg,
    output gtp_pkg::cfg_t cfg_vals
);

    gtp_pkg::cfg_t cfg_reg;
    gtp_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_vals  = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                gtp_pkg::REG_PHASE_STEP: cfg_next.phase_step = cfg.data;
                gtp_pkg::REG_X_SPAN:     cfg_next.x_span     = cfg.data;
                gtp_pkg::REG_Y_SPAN:     cfg_next.y_span     = cfg.data;
                default:                 cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step <= gtp_pkg::PHASE_STEP_RESET;
            cfg_reg.x_span     <= gtp_pkg::X_SPAN_RESET;
            cfg_reg.y_span     <= gtp_pkg::Y_SPAN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    `GTP_ASSERT(cfg_unknown_index_ignored, cfg.valid && cfg.ready && cfg.index != gtp_pkg::REG_PHASE_STEP && cfg.index != gtp_pkg::REG_X_SPAN && cfg.index != gtp_pkg::REG_Y_SPAN |=> $stable(cfg_reg), "write to an unknown register changed the settings")

endmodule

`default_nettype wire

>>> design/gtp_index.sv
`default_nettype none
`include "assert_macros.svh"

module gtp_index #(
    parameter int FRAME_WIDTH  = gtp_pkg::FRAME_WIDTH_DEFAULT,
    parameter int FRAME_HEIGHT = gtp_pkg::FRAME_HEIGHT_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            advance,
    input  wire logic                            in_valid,
    input  wire logic [gtp_pkg::FRAME_CNT_W-1:0] frame_count,
    input  wire logic [gtp_pkg::ROW_W-1:0]       row,
    input  wire logic [gtp_pkg::COL_W-1:0]       column,
    input  wire gtp_pkg::cfg_t                   cfg_vals,
    output gtp_pkg::idx_beat_t                   beat
);

    localparam int IDX_W = gtp_pkg::IDX_W;

    localparam int Y_NUM_W   = gtp_pkg::ROW_W + gtp_pkg::CFG_W;
    localparam int Y_DIV     = (FRAME_HEIGHT > 1) ? FRAME_HEIGHT - 1 : 1;
    localparam int Y_SHIFT   = Y_NUM_W + $clog2(Y_DIV);
    localparam int Y_RECIP_W = Y_NUM_W + 2;
    localparam int Y_PROD_W  = Y_SHIFT + IDX_W;
    localparam logic [Y_RECIP_W-1:0] Y_RECIP =
        Y_RECIP_W'(((longint'(1) << Y_SHIFT) + Y_DIV - 1) / Y_DIV);

    localparam int X_NUM_W   = gtp_pkg::COL_W + gtp_pkg::CFG_W;
    localparam int X_DIV     = (FRAME_WIDTH > 1) ? FRAME_WIDTH - 1 : 1;
    localparam int X_SHIFT   = X_NUM_W + $clog2(X_DIV);
    localparam int X_RECIP_W = X_NUM_W + 2;
    localparam int X_PROD_W  = X_SHIFT + IDX_W;
    localparam logic [X_RECIP_W-1:0] X_RECIP =
        X_RECIP_W'(((longint'(1) << X_SHIFT) + X_DIV - 1) / X_DIV);

    localparam int PHASE_PROD_W = gtp_pkg::FRAME_CNT_W + gtp_pkg::CFG_W;
    localparam int NUM_FULL_W   = 2 * IDX_W;

    logic [PHASE_PROD_W-1:0] phase_prod;
    logic [Y_NUM_W-1:0]      y_num;
    logic [X_NUM_W-1:0]      x_num;

    logic                s1_valid_reg;
    logic [IDX_W-1:0]    s1_phase_reg;
    logic [Y_NUM_W-1:0]  s1_ynum_reg;
    logic [X_NUM_W-1:0]  s1_xnum_reg;

    logic                s2_valid_reg;
    logic [IDX_W-1:0]    s2_phase_reg;
    logic [Y_PROD_W-1:0] s2_yprod_reg;
    logic [X_PROD_W-1:0] s2_xprod_reg;

    logic [IDX_W-1:0]            idx_next;
    gtp_pkg::seg_t               seg_next;
    logic [IDX_W-1:0]            diff;
    logic [NUM_FULL_W-1:0]       num_full;

    logic                        s3_valid_reg;
    logic [IDX_W-1:0]            s3_idx_reg;
    gtp_pkg::seg_t               s3_seg_reg;
    logic [gtp_pkg::T_NUM_W-1:0] s3_num_reg;

    assign phase_prod = PHASE_PROD_W'(frame_count) * PHASE_PROD_W'(cfg_vals.phase_step);
    assign y_num      = Y_NUM_W'(row) * Y_NUM_W'(cfg_vals.y_span);
    assign x_num      = X_NUM_W'(column) * X_NUM_W'(cfg_vals.x_span);

    // The index wraps modulo 256, so only the low byte of each term matters.
    assign idx_next = s2_phase_reg + s2_yprod_reg[Y_SHIFT +: IDX_W]
                    + s2_xprod_reg[X_SHIFT +: IDX_W];
    assign seg_next = gtp_pkg::seg_of(idx_next);
    assign diff     = idx_next - IDX_W'(gtp_pkg::STOP_POS[seg_next]);
    assign num_full = (NUM_FULL_W'(diff) << IDX_W) - NUM_FULL_W'(diff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_phase_reg <= phase_prod[IDX_W-1:0];
            s1_ynum_reg  <= y_num;
            s1_xnum_reg  <= x_num;

            s2_phase_reg <= s1_phase_reg;
            s2_yprod_reg <= Y_PROD_W'(s1_ynum_reg) * Y_PROD_W'(Y_RECIP);
            s2_xprod_reg <= X_PROD_W'(s1_xnum_reg) * X_PROD_W'(X_RECIP);

            s3_idx_reg   <= idx_next;
            s3_seg_reg   <= seg_next;
            s3_num_reg   <= num_full[gtp_pkg::T_NUM_W-1:0];
        end
    end

    assign beat.valid         = s3_valid_reg;
    assign beat.palette_index = s3_idx_reg;
    assign beat.seg           = s3_seg_reg;
    assign beat.num           = s3_num_reg;

    `GTP_ASSERT(idx_beat_moves_on, advance && s1_valid_reg |=> s2_valid_reg, "a beat was lost between the product stages")

endmodule

`default_nettype wire

>>> design/gtp_color.sv
`default_nettype none
`include "assert_macros.svh"

module gtp_color (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire gtp_pkg::idx_beat_t          beat,
    output logic                             out_valid,
    output logic [gtp_pkg::PIXEL_W-1:0]      pixel_word,
    output logic [gtp_pkg::IDX_W-1:0]        palette_index
);

    localparam int IDX_W    = gtp_pkg::IDX_W;
    localparam int CHAN     = gtp_pkg::CHAN_COUNT;
    localparam int MIX_W    = 2 * IDX_W;
    localparam int MIX_S_W  = MIX_W + 2;
    localparam int DELTA_W  = IDX_W + 1;
    localparam int QSUM_W   = MIX_W + 1;
    localparam int T_PROD_W = gtp_pkg::T_PROD_W;

    logic                s4_valid_reg;
    logic [IDX_W-1:0]    s4_idx_reg;
    gtp_pkg::seg_t       s4_seg_reg;
    logic [T_PROD_W-1:0] s4_prod_reg;

    logic [IDX_W-1:0]           t_val;
    logic [IDX_W-1:0]           lo_c    [CHAN];
    logic [IDX_W-1:0]           hi_c    [CHAN];
    logic signed [DELTA_W-1:0]  delta_c [CHAN];
    logic [MIX_W-1:0]           base_c  [CHAN];
    logic signed [MIX_S_W-1:0]  mix_s_c [CHAN];

    logic             s5_valid_reg;
    logic [IDX_W-1:0] s5_idx_reg;
    logic [MIX_W-1:0] s5_mix_reg [CHAN];

    logic [QSUM_W-1:0] qsum_c [CHAN];
    logic [IDX_W-1:0]  chan_c [CHAN];
    logic [gtp_pkg::PIXEL_W-1:0] rgb565;

    logic                        out_valid_reg;
    logic [gtp_pkg::PIXEL_W-1:0] pixel_word_reg;
    logic [IDX_W-1:0]            palette_index_reg;

    assign t_val = s4_prod_reg[gtp_pkg::T_SHIFT +: IDX_W];

    // Each channel is a*(255-t) + b*t, written as a*255 + (b-a)*t.
    always_comb
    begin
        for (int c = 0; c < CHAN; c++)
        begin
            lo_c[c]    = IDX_W'(gtp_pkg::STOP_RGB[s4_seg_reg][c]);
            hi_c[c]    = IDX_W'(gtp_pkg::STOP_RGB[int'(s4_seg_reg) + 1][c]);
            delta_c[c] = signed'(DELTA_W'(hi_c[c])) - signed'(DELTA_W'(lo_c[c]));
            base_c[c]  = (MIX_W'(lo_c[c]) << IDX_W) - MIX_W'(lo_c[c]);
            mix_s_c[c] = signed'(MIX_S_W'(base_c[c]))
                       + delta_c[c] * signed'({1'b0, t_val});
        end
    end

    // Exact division by 255 for any value up to 255*255.
    always_comb
    begin
        for (int c = 0; c < CHAN; c++)
        begin
            qsum_c[c] = QSUM_W'(s5_mix_reg[c]) + QSUM_W'(s5_mix_reg[c] >> IDX_W)
                      + QSUM_W'(1);
            chan_c[c] = qsum_c[c][IDX_W +: IDX_W];
        end
    end

    assign rgb565 = {chan_c[0][7:3], chan_c[1][7:2], chan_c[2][7:3]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s4_valid_reg  <= beat.valid;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_idx_reg  <= beat.palette_index;
            s4_seg_reg  <= beat.seg;
            s4_prod_reg <= T_PROD_W'(beat.num) * T_PROD_W'(gtp_pkg::T_RECIP[beat.seg]);

            s5_idx_reg  <= s4_idx_reg;
            for (int c = 0; c < CHAN; c++)
            begin
                s5_mix_reg[c] <= mix_s_c[c][MIX_W-1:0];
            end

            palette_index_reg <= s5_idx_reg;
            pixel_word_reg    <= {rgb565[IDX_W-1:0], rgb565[MIX_W-1:IDX_W]};
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_word    = pixel_word_reg;
    assign palette_index = palette_index_reg;

    `GTP_ASSERT_NEVER(color_blend_in_range, s4_valid_reg && (s4_prod_reg >> (gtp_pkg::T_SHIFT + IDX_W)) != '0, "blend position exceeds 255")

endmodule

`default_nettype wire

>>> design/gradient_test_pattern_pixel.sv
// Channel  Role    Payload
// req      sink    frame_count[7:0], row[8:0], column[7:0]
// pix      source  pixel_word[15:0], palette_index[7:0]
// cfg      sink    index[1:0], data[7:0]
//
// One beat per clock sustained while pix does not stall; a req beat passes through every stage to pix.
// The six register stages share one enable, high when the output register is
// empty or its beat is being taken, so req.ready follows pix.ready.
// A stall on pix freezes every stage; no beat is dropped or repeated.
// Reset clears the valid bits and loads the register defaults; cfg is always ready.
`default_nettype none

module gradient_test_pattern_pixel #(
    parameter int FRAME_WIDTH  = gtp_pkg::FRAME_WIDTH_DEFAULT,
    parameter int FRAME_HEIGHT = gtp_pkg::FRAME_HEIGHT_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gtp_req_if.sink   req,
    gtp_pix_if.source pix,
    gtp_cfg_if.sink   cfg
);

    gtp_pkg::cfg_t      cfg_vals;
    gtp_pkg::idx_beat_t idx_beat;
    logic               advance;
    logic               pix_valid;

    assign advance   = !pix_valid || pix.ready;
    assign req.ready = advance;
    assign pix.valid = pix_valid;

    gtp_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_vals (cfg_vals)
    );

    gtp_index #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_index (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (req.valid),
        .frame_count (req.frame_count),
        .row         (req.row),
        .column      (req.column),
        .cfg_vals    (cfg_vals),
        .beat        (idx_beat)
    );

    gtp_color u_color (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .beat          (idx_beat),
        .out_valid     (pix_valid),
        .pixel_word    (pix.pixel_word),
        .palette_index (pix.palette_index)
    );

endmodule

`default_nettype wire

>>> dv/gradient_test_pattern_pixel_test.sv
`timescale 1ns / 1ps

module gradient_test_pattern_pixel_test;

    localparam int FRAME_CNT_W = gtp_pkg::FRAME_CNT_W;
    localparam int ROW_W       = gtp_pkg::ROW_W;
    localparam int COL_W       = gtp_pkg::COL_W;
    localparam int CFG_W       = gtp_pkg::CFG_W;
    localparam int IDX_W       = gtp_pkg::IDX_W;
    localparam int PIXEL_W     = gtp_pkg::PIXEL_W;
    localparam int CFG_INDEX_W = gtp_pkg::CFG_INDEX_W;

    localparam int CLK_HIGH       = 6;
    localparam int CLK_LOW        = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int LATENCY_MARGIN = 10;
    localparam int HOLD_CYCLES    = 80;
    localparam int PRESSURE_ITEMS = 40;
    localparam int PHASE_ITEMS    = 150;
    localparam int PHASE_COUNT    = 7;
    localparam int MAX_REPORTS    = 10;
    localparam int GRAD_WIDTH     = 240;
    localparam int GRAD_HEIGHT    = 320;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    localparam int PAL_POS   [5] = '{0, 58, 118, 185, 255};
    localparam int PAL_RED   [5] = '{20, 0, 70, 255, 245};
    localparam int PAL_GREEN [5] = '{34, 205, 255, 190, 65};
    localparam int PAL_BLUE  [5] = '{105, 255, 150, 65, 190};

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_word;
        logic [IDX_W-1:0]   palette_index;
    } pixel_result_t;

    typedef struct packed {
        logic [FRAME_CNT_W-1:0] frame_count;
        logic [ROW_W-1:0]       row;
        logic [COL_W-1:0]       column;
        logic                   known;
        pixel_result_t          result;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 14;

    // Rows marked known carry a value read straight off the color stops.
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{8'd0,   9'd0,   8'd0,   1'b1, '{16'h0D11, 8'd0}},
        '{8'd0,   9'd0,   8'd89,  1'b1, '{16'h7F06, 8'd58}},
        '{8'd85,  9'd0,   8'd0,   1'b1, '{16'h17F2, 8'd255}},
        '{8'd0,   9'd319, 8'd239, 1'b1, '{16'h0D11, 8'd0}},
        '{8'd0,   9'd0,   8'd181, 1'b0, '{16'h0000, 8'd0}},
        '{8'd61,  9'd0,   8'd4,   1'b0, '{16'h0000, 8'd0}},
        '{8'd255, 9'd511, 8'd255, 1'b0, '{16'h0000, 8'd0}},
        '{8'd0,   9'd319, 8'd0,   1'b0, '{16'h0000, 8'd0}},
        '{8'd0,   9'd0,   8'd239, 1'b0, '{16'h0000, 8'd0}},
        '{8'd1,   9'd0,   8'd0,   1'b0, '{16'h0000, 8'd0}},
        '{8'd0,   9'd320, 8'd240, 1'b0, '{16'h0000, 8'd0}},
        '{8'd170, 9'd256, 8'd128, 1'b0, '{16'h0000, 8'd0}},
        '{8'd85,  9'd255, 8'd127, 1'b0, '{16'h0000, 8'd0}},
        '{8'd0,   9'd1,   8'd1,   1'b0, '{16'h0000, 8'd0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    gtp_req_if req_ch ();
    gtp_pix_if pix_ch ();
    gtp_cfg_if cfg_ch ();

    gradient_test_pattern_pixel i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .pix   (pix_ch),
        .cfg   (cfg_ch)
    );

    logic [CFG_W-1:0] phase_step_q;
    logic [CFG_W-1:0] x_span_q;
    logic [CFG_W-1:0] y_span_q;

    pixel_result_t expected_pixels[$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    int            send_idle_pct  = 0;
    int            pix_stall_pct  = 0;
    logic          hold_requested = 1'b0;
    logic          hold_active;

    always
    begin
        #CLK_LOW clk = 1'b1;
        #CLK_HIGH clk = 1'b0;
    end

    function automatic pixel_result_t compute_gradient_pixel(
        input logic [FRAME_CNT_W-1:0] frame,
        input logic [ROW_W-1:0]       row,
        input logic [COL_W-1:0]       column
    );
        int unsigned   sum;
        int            idx;
        int            seg;
        int            t;
        int            red;
        int            green;
        int            blue;
        logic [15:0]   color;
        pixel_result_t res;
        sum = int'(frame) * int'(phase_step_q)
            + (int'(row) * int'(y_span_q)) / (GRAD_HEIGHT - 1)
            + (int'(column) * int'(x_span_q)) / (GRAD_WIDTH - 1);
        idx = int'(sum % 256);
        seg = 3;
        for (int s = 3; s >= 0; s--)
        begin
            if (idx inside {[PAL_POS[s]:PAL_POS[s + 1]]})
            begin
                seg = s;
            end
        end
        t = ((idx - PAL_POS[seg]) * 255) / (PAL_POS[seg + 1] - PAL_POS[seg]);
        red   = (PAL_RED[seg] * (255 - t) + PAL_RED[seg + 1] * t) / 255;
        green = (PAL_GREEN[seg] * (255 - t) + PAL_GREEN[seg + 1] * t) / 255;
        blue  = (PAL_BLUE[seg] * (255 - t) + PAL_BLUE[seg + 1] * t) / 255;
        color = {red[7:3], green[7:2], blue[7:3]};
        res.pixel_word    = {color[7:0], color[15:8]};
        res.palette_index = idx[7:0];
        return res;
    endfunction

    task automatic push_request(
        input logic [FRAME_CNT_W-1:0] frame,
        input logic [ROW_W-1:0]       row,
        input logic [COL_W-1:0]       column,
        input logic                   known,
        input pixel_result_t          known_result
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.frame_count <= frame;
        req_ch.row         <= row;
        req_ch.column      <= column;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        if (known)
        begin
            expected_pixels.push_back(known_result);
        end
        else
        begin
            expected_pixels.push_back(compute_gradient_pixel(frame, row, column));
        end
        @(negedge clk);
    endtask

    task automatic push_random_request();
        logic [FRAME_CNT_W-1:0] frame;
        logic [ROW_W-1:0]       row;
        logic [COL_W-1:0]       column;
        frame  = FRAME_CNT_W'($urandom_range(255));
        row    = ($urandom_range(9) == 0) ? ROW_W'($urandom_range(511))
                                          : ROW_W'($urandom_range(GRAD_HEIGHT - 1));
        column = ($urandom_range(9) == 0) ? COL_W'($urandom_range(255))
                                          : COL_W'($urandom_range(GRAD_WIDTH - 1));
        push_request(frame, row, column, 1'b0, '0);
    endtask

    task automatic write_register(
        input logic [CFG_INDEX_W-1:0] index,
        input logic [CFG_W-1:0]       data
    );
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        case (index)
            gtp_pkg::REG_PHASE_STEP: phase_step_q = data;
            gtp_pkg::REG_X_SPAN:     x_span_q = data;
            gtp_pkg::REG_Y_SPAN:     y_span_q = data;
            default:                 ;
        endcase
        @(negedge clk);
    endtask

    task automatic settle_pipeline();
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY_MARGIN) @(negedge clk);
    endtask

    task automatic apply_phase_settings(input int phase);
        logic [CFG_W-1:0] step;
        logic [CFG_W-1:0] xs;
        logic [CFG_W-1:0] ys;
        case (phase)
            1:
            begin
                step = 8'd0;
                xs   = 8'd0;
                ys   = 8'd0;
            end
            2:
            begin
                step = 8'd255;
                xs   = 8'd255;
                ys   = 8'd255;
            end
            3:
            begin
                step = 8'd1;
                xs   = 8'd255;
                ys   = 8'd255;
            end
            default:
            begin
                step = CFG_W'($urandom_range(255));
                xs   = CFG_W'($urandom_range(255));
                ys   = CFG_W'($urandom_range(255));
            end
        endcase
        write_register(gtp_pkg::REG_PHASE_STEP, step);
        write_register(REG_UNUSED, CFG_W'($urandom_range(255)));
        write_register(gtp_pkg::REG_X_SPAN, xs);
        write_register(gtp_pkg::REG_Y_SPAN, ys);
        cfg_ch.valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        pix_ch.ready <= !hold_active && ($urandom_range(99) >= pix_stall_pct);
    end

    initial
    begin
        hold_active = 1'b0;
        wait (hold_requested);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active <= 1'b0;
    end

    always @(posedge clk)
    begin : pixel_monitor
        pixel_result_t expected_beat;
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("unexpected pixel beat: pixel_word %h palette_index %0d",
                             pix_ch.pixel_word, pix_ch.palette_index);
                end
            end
            else
            begin
                expected_beat = expected_pixels.pop_front();
                if (pix_ch.pixel_word !== expected_beat.pixel_word ||
                    pix_ch.palette_index !== expected_beat.palette_index)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("pixel mismatch: expected %h/%0d, got %h/%0d",
                                 expected_beat.pixel_word, expected_beat.palette_index,
                                 pix_ch.pixel_word, pix_ch.palette_index);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.frame_count = '0;
        req_ch.row         = '0;
        req_ch.column      = '0;
        pix_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = gtp_pkg::REG_PHASE_STEP;
        cfg_ch.data        = '0;
        phase_step_q       = gtp_pkg::PHASE_STEP_RESET;
        x_span_q           = gtp_pkg::X_SPAN_RESET;
        y_span_q           = gtp_pkg::Y_SPAN_RESET;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            push_request(DIRECTED_ROWS[i].frame_count, DIRECTED_ROWS[i].row,
                         DIRECTED_ROWS[i].column, DIRECTED_ROWS[i].known,
                         DIRECTED_ROWS[i].result);
        end

        // The sink holds off while requests keep coming, so the pipeline fills.
        hold_requested = 1'b1;
        repeat (PRESSURE_ITEMS) push_random_request();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase > 0)
            begin
                req_ch.valid <= 1'b0;
                settle_pipeline();
                apply_phase_settings(phase);
            end
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    pix_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 84;
                    pix_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    pix_stall_pct = 84;
                end
                default:
                begin
                    send_idle_pct = 37;
                    pix_stall_pct = 37;
                end
            endcase
            repeat (PHASE_ITEMS) push_random_request();
        end

        req_ch.valid <= 1'b0;
        pix_stall_pct = 0;
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY_MARGIN) @(posedge clk);

        if (mismatch_count == 0 && expected_pixels.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/gtp_pkg.sv
design/gtp_req_if.sv
design/gtp_pix_if.sv
design/gtp_cfg_if.sv
design/gtp_cfg_regs.sv
design/gtp_index.sv
design/gtp_color.sv
design/gradient_test_pattern_pixel.sv
dv/gradient_test_pattern_pixel_test.sv
